>>> src/vtes_pkg.sv
`timescale 1ns / 1ps

package vtes_pkg;

  // Command codes carried on kind_i
  typedef enum logic [2:0] {
    KIND_CLEAR   = 3'd0,
    KIND_APPEND  = 3'd1,
    KIND_REPLACE = 3'd2,
    KIND_DELETE  = 3'd3,
    KIND_SEARCH  = 3'd4
  } kind_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  localparam int unsigned ValueW      = 32;
  localparam int unsigned OutIndexW   = 4;
  localparam int unsigned OutCountW   = 5;

endpackage

>>> src/value_table_edit_search_core.sv
`timescale 1ns / 1ps

// Table of up to CAPACITY signed 32-bit values with an entry count, driven by
// one command per input beat: clear, append, replace all matches, delete the
// first match (later entries shift down), or search for the first match. Each
// command returns one result beat with found, match index, entry count after
// the command, and a full flag for a refused append. The values sit in a
// single-port-read, single-port-write memory with registered read data, and
// one sequencer walks it one entry per cycle through a single 32-bit
// comparator. Clear, append and unused codes go from the accept straight to
// the done state, which loads their result into the output register;
// replace, delete and search first walk the table in the scan state (search
// stops early at its first hit), then load their result in the done state.
// The next command is accepted in the cycle after the result is loaded. The
// block takes one command at a time; a finished result waits in the output
// register until taken, and the sequencer holds its next result until that
// register frees. The memory needs no clearing: only entries below the count
// are ever read.
module value_table_edit_search_core
  import vtes_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0]                  kind_i,
  input  logic signed [ValueW-1:0]    match_value_i,
  input  logic signed [ValueW-1:0]    new_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        found_o,
  output logic [OutIndexW-1:0]        match_index_o,
  output logic [OutCountW-1:0]        entry_count_o,
  output logic                        full_error_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  // Control state
  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [CntW-1:0]     rd_idx_q, rd_idx_d;
  logic                cmp_vld_q, cmp_vld_d;
  logic                found_q, found_d;
  logic                full_q, full_d;
  logic                out_valid_q, out_valid_d;

  // Payload state
  logic [IdxW-1:0]     cmp_idx_q, cmp_idx_d;
  logic [IdxW-1:0]     fidx_q, fidx_d;
  logic [2:0]          kind_q;
  logic signed [ValueW-1:0] mv_q, nv_q;
  logic                out_found_q;
  logic [OutIndexW-1:0] out_index_q;
  logic [OutCountW-1:0] out_count_q;
  logic                out_full_q;

  // Memory
  logic signed [ValueW-1:0] mem_q [CAPACITY];
  logic signed [ValueW-1:0] rdata_q;
  logic                mem_we, mem_re;
  logic [IdxW-1:0]     mem_waddr, mem_raddr;
  logic signed [ValueW-1:0] mem_wdata;

  logic                in_fire, out_load, issue, hit;
  logic [IdxW+OutIndexW-1:0] idx_ext;
  logic [CntW+OutCountW-1:0] cnt_ext;

  assign in_fire = in_valid_i && in_ready_o;
  assign issue   = rd_idx_q < cnt_q;
  assign hit     = cmp_vld_q && (rdata_q == mv_q);
  assign idx_ext = (IdxW + OutIndexW)'(fidx_q);
  assign cnt_ext = (CntW + OutCountW)'(cnt_q);

  // Sequencer: next state, memory strobes, result capture
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rd_idx_d    = rd_idx_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    found_d     = found_q;
    fidx_d      = fidx_q;
    full_d      = full_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_load    = 1'b0;
    in_ready_o  = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = rd_idx_q[IdxW-1:0];

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          found_d  = 1'b0;
          fidx_d   = '0;
          full_d   = 1'b0;
          rd_idx_d = '0;
          state_d  = S_DONE;
          unique case (kind_e'(kind_i))
            KIND_CLEAR: cnt_d = '0;
            KIND_APPEND: begin
              if (cnt_q < CapCnt) begin
                mem_we    = 1'b1;
                mem_waddr = cnt_q[IdxW-1:0];
                mem_wdata = match_value_i;
                cnt_d     = cnt_q + CntW'(1);
              end else begin
                full_d = 1'b1;
              end
            end
            KIND_REPLACE, KIND_DELETE, KIND_SEARCH: state_d = S_SCAN;
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        // Issue the next read
        if (issue) begin
          mem_re    = 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_idx_q[IdxW-1:0];
          rd_idx_d  = rd_idx_q + CntW'(1);
        end
        // Compare the entry read last cycle
        if (cmp_vld_q) begin
          unique case (kind_e'(kind_q))
            KIND_REPLACE: begin
              if (hit) begin
                mem_we    = 1'b1;
                mem_waddr = cmp_idx_q;
                mem_wdata = nv_q;
                if (!found_q) begin
                  found_d = 1'b1;
                  fidx_d  = cmp_idx_q;
                end
              end
            end
            KIND_DELETE: begin
              if (found_q) begin
                // shift this entry down by one slot
                mem_we    = 1'b1;
                mem_waddr = cmp_idx_q - IdxW'(1);
                mem_wdata = rdata_q;
              end else if (hit) begin
                found_d = 1'b1;
                fidx_d  = cmp_idx_q;
              end
            end
            KIND_SEARCH: begin
              if (hit) begin
                found_d = 1'b1;
                fidx_d  = cmp_idx_q;
                state_d = S_DONE;
              end
            end
            default: ;
          endcase
        end
        // Walk finished: nothing issued, nothing left to compare
        if (!cmp_vld_q && !issue) begin
          state_d = S_DONE;
          if ((kind_e'(kind_q) == KIND_DELETE) && found_q) begin
            cnt_d = cnt_q - CntW'(1);
          end
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_idx_q    <= rd_idx_d;
      cmp_vld_q   <= cmp_vld_d;
      found_q     <= found_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: hold command operands and the result beat
  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    fidx_q    <= fidx_d;
    if (in_fire) begin
      kind_q <= kind_i;
      mv_q   <= match_value_i;
      nv_q   <= new_value_i;
    end
    if (out_load) begin
      out_found_q <= found_q;
      out_index_q <= idx_ext[OutIndexW-1:0];
      out_count_q <= cnt_ext[OutCountW-1:0];
      out_full_q  <= full_q;
    end
  end

  // Table memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = out_found_q;
  assign match_index_o = out_index_q;
  assign entry_count_o = out_count_q;
  assign full_error_o  = out_full_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CapCnt)
    else $error("entry count above capacity");

  a_full_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(full_error_o && found_o))
    else $error("full flag and found both set");

  a_miss_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (match_index_o == '0))
    else $error("nonzero index without a match");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o)
    else $error("input ready while sequencer busy");
`endif

endmodule
